// ----- rtl/core/atl_pkg.sv -----
// Shared types, character codes and keyword tables for the assembly token lexer.
`default_nettype none

package atl_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 256;
    localparam int TEXT_LEN_W        = 9;
    localparam int FIFO_DEPTH        = 4;

    typedef enum logic [3:0] {
        K_NEWLINE = 4'd0,
        K_COMMA   = 4'd1,
        K_LBRACK  = 4'd2,
        K_RBRACK  = 4'd3,
        K_IMM     = 4'd4,
        K_LABEL   = 4'd5,
        K_REG     = 4'd6,
        K_MNEM    = 4'd7,
        K_IDENT   = 4'd8,
        K_EOF     = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COMMENT = 3'd1,
        M_MINUS   = 3'd2,
        M_NUMBER  = 3'd3,
        M_WORD    = 3'd4
    } t_mode;

    typedef struct packed {
        t_kind                  kind;
        logic [31:0]            value;
        logic [TEXT_LEN_W-1:0]  len;
        logic [63:0]            head;
        logic                   last;
    } t_token;

    // tokens produced by one input transaction
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    localparam int NUM_REGS = 8;
    localparam int NUM_OPS  = 13;
    localparam int REG_LEN  = 3;

    // packed text, first character in the low byte
    localparam logic [63:0] REG_TEXT [NUM_REGS] = '{
        64'h786165, 64'h786365, 64'h786465, 64'h786265,
        64'h707365, 64'h706265, 64'h697365, 64'h696465
    };

    localparam logic [63:0] OP_TEXT [NUM_OPS] = '{
        64'h766F6D, 64'h68737570, 64'h706F70, 64'h646461,
        64'h627573, 64'h706D63, 64'h706D6A, 64'h656A,
        64'h656E6A, 64'h6C6C6163, 64'h746572, 64'h746E69,
        64'h706F6E
    };

    localparam int OP_LEN [NUM_OPS] = '{3, 4, 3, 3, 3, 3, 3, 2, 3, 4, 3, 3, 3};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
               (c == CH_UNDER) || (c == CH_DOT);
    endfunction

    function automatic t_token mk_token(input t_kind kind, input logic [31:0] value,
                                        input logic [TEXT_LEN_W-1:0] len,
                                        input logic [63:0] head);
        t_token t;
        t.kind  = kind;
        t.value = value;
        t.len   = len;
        t.head  = head;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/atl_keyword.sv -----
// Register name and mnemonic classifier for a pending word.
`default_nettype none

module atl_keyword
    import atl_pkg::*;
#(
    parameter int LW = 9
) (
    input  wire logic [63:0]   i_head,
    input  wire logic [LW-1:0] i_len,
    output t_kind              o_kind,
    output logic [31:0]        o_value
);

    logic                        reg_hit;
    logic                        op_hit;
    logic [$clog2(NUM_REGS)-1:0] reg_idx;

    always_comb begin
        reg_hit = 1'b0;
        op_hit  = 1'b0;
        reg_idx = '0;
        // downward so the lowest matching index wins
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if ((i_len == LW'(REG_LEN)) && (i_head == REG_TEXT[i])) begin
                reg_hit = 1'b1;
                reg_idx = ($clog2(NUM_REGS))'(i);
            end
        end
        for (int i = 0; i < NUM_OPS; i++) begin
            if ((i_len == LW'(OP_LEN[i])) && (i_head == OP_TEXT[i])) begin
                op_hit = 1'b1;
            end
        end
        if (reg_hit) begin
            o_kind  = K_REG;
            o_value = 32'(reg_idx);
        end else if (op_hit) begin
            o_kind  = K_MNEM;
            o_value = '0;
        end else begin
            o_kind  = K_IDENT;
            o_value = '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/atl_scan.sv -----
// Lexer state registers and per-byte scanning step, up to two tokens per byte.
`default_nettype none

module atl_scan
    import atl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_source,
    output t_push           o_push
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    t_mode         r_mode,  n_mode;
    logic [31:0]   r_acc,   n_acc;
    logic          r_neg,   n_neg;
    logic [63:0]   r_head,  n_head;
    logic [LW-1:0] r_len,   n_len;

    t_kind         kw_kind;
    logic [31:0]   kw_value;
    logic [LW+8:0] len_ext;
    logic [TEXT_LEN_W-1:0] cur_len;
    logic [31:0]   num_value;
    t_token        v_tok [2];
    logic [1:0]    v_cnt;
    logic          go_idle;
    logic [7:0]    c;

    function automatic logic [63:0] app_head(input logic [63:0] head, input logic [LW-1:0] len,
                                             input logic [7:0] ch);
        logic [63:0] h;
        h = head;
        for (int i = 0; i < 8; i++) begin
            if (len == LW'(i)) h[8*i +: 8] = ch;
        end
        return h;
    endfunction

    function automatic logic [LW-1:0] app_len(input logic [LW-1:0] len);
        return (len < LW'(MAX_TOKEN_LEN)) ? len + LW'(1) : len;
    endfunction

    atl_keyword #(.LW(LW)) u_keyword (
        .i_head  (r_head),
        .i_len   (r_len),
        .o_kind  (kw_kind),
        .o_value (kw_value)
    );

    assign c         = i_in_byte;
    assign len_ext   = {9'b0, r_len};
    assign cur_len   = len_ext[TEXT_LEN_W-1:0];
    assign num_value = r_neg ? 32'd0 - r_acc : r_acc;

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_head   = r_head;
        n_len    = r_len;
        v_tok[0] = mk_token(K_EOF, '0, '0, '0);
        v_tok[1] = mk_token(K_EOF, '0, '0, '0);
        v_cnt    = 2'd0;
        go_idle  = 1'b0;

        if (i_end_of_source) begin
            if (r_mode == M_NUMBER) begin
                v_tok[0] = mk_token(K_IMM, num_value, cur_len, r_head);
                v_cnt    = 2'd1;
            end else if (r_mode == M_WORD) begin
                v_tok[0] = mk_token(kw_kind, kw_value, cur_len, r_head);
                v_cnt    = 2'd1;
            end
            v_tok[v_cnt[0]] = mk_token(K_EOF, '0, '0, '0);
            v_cnt  = v_cnt + 2'd1;
            n_mode = M_IDLE;
            n_acc  = '0;
            n_neg  = 1'b0;
            n_head = '0;
            n_len  = '0;
        end else begin
            unique case (r_mode)
                M_COMMENT: begin
                    if (c == CH_LF) begin
                        v_tok[0] = mk_token(K_NEWLINE, '0, TEXT_LEN_W'(1), 64'(CH_LF));
                        v_cnt    = 2'd1;
                        n_mode   = M_IDLE;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c)) begin
                        n_acc  = (r_acc << 3) + (r_acc << 1) + 32'(c - CH_ZERO);
                        n_head = app_head(r_head, r_len, c);
                        n_len  = app_len(r_len);
                    end else begin
                        v_tok[0] = mk_token(K_IMM, num_value, cur_len, r_head);
                        v_cnt    = 2'd1;
                        n_mode   = M_IDLE;
                        go_idle  = 1'b1;
                    end
                end
                M_WORD: begin
                    if (is_word_start(c) || is_digit(c)) begin
                        n_head = app_head(r_head, r_len, c);
                        n_len  = app_len(r_len);
                    end else begin
                        n_mode = M_IDLE;
                        v_cnt  = 2'd1;
                        if (c == CH_COLON) begin
                            v_tok[0] = mk_token(K_LABEL, '0, cur_len, r_head);
                        end else begin
                            v_tok[0] = mk_token(kw_kind, kw_value, cur_len, r_head);
                            go_idle  = 1'b1;
                        end
                    end
                end
                M_MINUS: begin
                    if (is_digit(c)) begin
                        n_mode = M_NUMBER;
                        n_neg  = 1'b1;
                        n_acc  = 32'(c - CH_ZERO);
                        n_head = app_head(64'(CH_MINUS), LW'(1), c);
                        n_len  = LW'(2);
                    end else begin
                        n_mode  = M_IDLE;
                        go_idle = 1'b1;
                    end
                end
                default: begin
                    n_mode  = M_IDLE;
                    go_idle = 1'b1;
                end
            endcase

            if (go_idle) begin
                case (c)
                    CH_SPACE, CH_TAB: ;
                    CH_SEMI:   n_mode = M_COMMENT;
                    CH_LF: begin
                        v_tok[v_cnt[0]] = mk_token(K_NEWLINE, '0, TEXT_LEN_W'(1), 64'(CH_LF));
                        v_cnt = v_cnt + 2'd1;
                    end
                    CH_COMMA: begin
                        v_tok[v_cnt[0]] = mk_token(K_COMMA, '0, TEXT_LEN_W'(1), 64'(CH_COMMA));
                        v_cnt = v_cnt + 2'd1;
                    end
                    CH_LBRACK: begin
                        v_tok[v_cnt[0]] = mk_token(K_LBRACK, '0, TEXT_LEN_W'(1),
                                                   64'(CH_LBRACK));
                        v_cnt = v_cnt + 2'd1;
                    end
                    CH_RBRACK: begin
                        v_tok[v_cnt[0]] = mk_token(K_RBRACK, '0, TEXT_LEN_W'(1),
                                                   64'(CH_RBRACK));
                        v_cnt = v_cnt + 2'd1;
                    end
                    CH_MINUS:  n_mode = M_MINUS;
                    default: begin
                        if (is_digit(c)) begin
                            n_mode = M_NUMBER;
                            n_neg  = 1'b0;
                            n_acc  = 32'(c - CH_ZERO);
                            n_head = 64'(c);
                            n_len  = LW'(1);
                        end else if (is_word_start(c)) begin
                            n_mode = M_WORD;
                            n_head = 64'(c);
                            n_len  = LW'(1);
                        end
                    end
                endcase
            end
        end

        // flag the final token of this byte
        if (v_cnt == 2'd2) begin
            v_tok[1].last = 1'b1;
        end else if (v_cnt == 2'd1) begin
            v_tok[0].last = 1'b1;
        end

        o_push.cnt  = i_accept ? v_cnt : 2'd0;
        o_push.tok0 = v_tok[0];
        o_push.tok1 = v_tok[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_head <= '0;
            r_len  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_head <= n_head;
            r_len  <= n_len;
        end
    end

    a_eos_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_source) |=> (r_mode == M_IDLE && r_len == '0 && r_acc == '0))
        else $error("state not cleared after end of source");

    a_eos_last_is_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_source) |->
        ((o_push.cnt == 2'd1 && o_push.tok0.kind == K_EOF) ||
         (o_push.cnt == 2'd2 && o_push.tok1.kind == K_EOF)))
        else $error("end of source without trailing EOF token");

    a_two_tokens_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (!o_push.tok0.last && o_push.tok1.last))
        else $error("last flag misplaced on token pair");

endmodule

`default_nettype wire

// ----- rtl/core/atl_fifo.sv -----
// Token queue: takes up to two tokens per cycle while it has room, delivers one when popped.
`default_nettype none

module atl_fifo
    import atl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    output logic        o_room,
    output logic        o_valid,
    input  wire logic   i_pop,
    output t_token      o_token
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_token        r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(FIFO_DEPTH - 2));
    assign o_token = r_mem[r_rd];
    assign pop     = o_valid && i_pop;

    always_comb begin
        n_wr    = r_wr + AW'(i_push.cnt);
        n_rd    = pop ? r_rd + AW'(1) : r_rd;
        n_count = r_count + CW'(i_push.cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.tok0;
        if (i_push.cnt == 2'd2) r_mem[r_wr + AW'(1)] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("token queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("push without room");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_wr - r_rd) == AW'(r_count))
        else $error("pointers disagree with count");

endmodule

`default_nettype wire

// ----- rtl/core/assembly_token_lexer.sv -----
// Top level of the streaming assembly token lexer.
// Input channel: one source byte per transaction on i_in_byte, or an end-of-source
// marker on i_end_of_source (byte ignored then). Accepted when i_valid is high and
// o_stall low. Output channel: one token per transaction, accepted when o_valid is
// high and i_stall low; o_last_result marks the final token caused by a byte.
// A byte updates the lexer state in the cycle it is accepted; its tokens (zero,
// one or two) go into a four-entry queue and appear on the outputs in the next
// cycle at the earliest. The input takes a byte every cycle while the queue has
// room for two tokens, so bytes giving at most one token run at one per cycle;
// a byte giving two tokens sends them out singly, the queue read port being
// the limit. When the receiver stalls the queue fills and o_stall rises once
// fewer than two entries are free; the head token holds steady meanwhile.
// Reset (synchronous, active low) returns the lexer to idle with empty text,
// zero accumulator, and empties the queue.
`default_nettype none

module assembly_token_lexer
    import atl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_source,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_token_kind,
    output logic [31:0]      o_token_value,
    output logic [8:0]       o_text_length,
    output logic [63:0]      o_text_head,
    output logic             o_last_result
);

    t_push  push;
    t_token head_tok;
    logic   room;
    logic   in_accept;

    // accept only when two queue slots are free, whatever the byte yields
    assign o_stall   = !room;
    assign in_accept = i_valid && room;

    atl_scan #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_in_byte       (i_in_byte),
        .i_end_of_source (i_end_of_source),
        .o_push          (push)
    );

    atl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_pop   (!i_stall),
        .o_token (head_tok)
    );

    assign o_token_kind  = head_tok.kind;
    assign o_token_value = head_tok.value;
    assign o_text_length = head_tok.len;
    assign o_text_head   = head_tok.head;
    assign o_last_result = head_tok.last;

endmodule

`default_nettype wire
